// ===== sv/nit_pkg.sv =====
// ----------------------------------------------------------------------------
// nit_pkg
// Shared types and codes for the note interval event tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package nit_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_SEEK    = 2'd3;

  localparam logic [1:0] EV_RESET      = 2'd0;
  localparam logic [1:0] EV_ACTIVATE   = 2'd1;
  localparam logic [1:0] EV_DEACTIVATE = 2'd2;

  localparam int unsigned RUN_WORDS = 64;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] time_ms;
    logic [31:0] note_start_ms;
    logic [31:0] note_end_ms;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [11:0] note_index;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/note_interval_event_tracker.sv =====
// ----------------------------------------------------------------------------
// note_interval_event_tracker
// Note interval table with activate / deactivate event generation.
// ----------------------------------------------------------------------------
// Clear and load complete in the accepting cycle; busy stays low.
// Advance: scans notes from the activate cursor, runs the binary search, then
//   emits the deactivate words; seek: emits the reset word, scans every table
//   entry, then runs the binary search.
// Words leave one per cycle at most, each on the strobe for a single cycle;
//   the receiver cannot stall. After 64 words with more pending, busy drops
//   and the next accepted start resumes the run.
// Synchronous reset empties the table and clears both cursors.
`default_nettype none

module note_interval_event_tracker #(
  parameter int unsigned NOTE_DEPTH = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire nit_pkg::cmd_t   cmd,
  output logic                 busy,
  output logic                 strobe,
  output nit_pkg::result_t     result
);

  localparam int unsigned CW = $clog2(NOTE_DEPTH + 1);
  localparam int unsigned AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ACT_RD   = 9'b000000010,
    ST_ACT_CMP  = 9'b000000100,
    ST_BS_RD    = 9'b000001000,
    ST_BS_CMP   = 9'b000010000,
    ST_DEACT    = 9'b000100000,
    ST_SEEK_RST = 9'b001000000,
    ST_SEEK_RD  = 9'b010000000,
    ST_SEEK_CMP = 9'b100000000
  } state_t;

  // Table storage: start/end pair in one memory, running maximum in another.
  logic [63:0] note_mem [NOTE_DEPTH];
  logic [31:0] rmax_mem [NOTE_DEPTH];
  logic [63:0] note_rd;
  logic [31:0] rmax_rd;

  state_t      state, state_next;
  logic [CW-1:0] note_count;
  logic [CW-1:0] act_cur;
  logic [CW-1:0] deact_cur;
  logic [CW-1:0] scan;
  logic [CW-1:0] lo, hi, bound;
  logic          found;
  logic          is_seek;
  logic [31:0]   run_time;
  logic [31:0]   max_last;
  logic          paused;
  logic [6:0]    emitted;
  logic          held_valid;
  logic [1:0]    held_kind;
  logic [CW-1:0] held_index;

  logic          accept;
  logic [CW-1:0] mid;
  logic [CW-1:0] rd_addr;
  logic          load_we;
  logic [31:0]   load_max;
  logic [31:0]   rd_start, rd_end;

  // Generator outputs for this cycle
  logic          ev_valid;
  logic [1:0]    ev_kind;
  logic [CW-1:0] ev_index;
  logic          gen_done;

  assign busy     = (state != ST_IDLE) && !paused;
  assign accept   = start && !busy;
  assign mid      = lo + ((hi - lo) >> 1);
  assign rd_start = note_rd[63:32];
  assign rd_end   = note_rd[31:0];

  assign load_we  = accept && !paused && (cmd.operation == nit_pkg::OP_LOAD)
                    && (note_count < CW'(NOTE_DEPTH));
  assign load_max = ((note_count != '0) && (max_last > cmd.note_end_ms)) ?
                    max_last : cmd.note_end_ms;

  // Read address follows the scan in progress
  always_comb begin
    unique case (state)
      ST_ACT_RD:  rd_addr = act_cur;
      ST_SEEK_RD: rd_addr = scan;
      ST_BS_RD:   rd_addr = mid;
      default:    rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      note_mem[note_count[AW-1:0]] <= {cmd.note_start_ms, cmd.note_end_ms};
      rmax_mem[note_count[AW-1:0]] <= load_max;
    end
    note_rd <= note_mem[rd_addr[AW-1:0]];
    rmax_rd <= rmax_mem[rd_addr[AW-1:0]];
  end

  // Event generator: walk the table, one decision per state
  always_comb begin
    state_next = state;
    ev_valid   = 1'b0;
    ev_kind    = nit_pkg::EV_RESET;
    ev_index   = '0;
    gen_done   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && cmd.operation == nit_pkg::OP_ADVANCE) begin
          state_next = ST_ACT_RD;
        end else if (accept && cmd.operation == nit_pkg::OP_SEEK) begin
          state_next = ST_SEEK_RST;
        end
      end
      ST_ACT_RD: begin
        state_next = (act_cur < note_count) ? ST_ACT_CMP : ST_BS_RD;
      end
      ST_ACT_CMP: begin
        if (run_time < rd_start) begin
          state_next = ST_BS_RD;
        end else begin
          state_next = ST_ACT_RD;
          if (run_time <= rd_end) begin
            ev_valid = 1'b1;
            ev_kind  = nit_pkg::EV_ACTIVATE;
            ev_index = act_cur;
          end
        end
      end
      ST_BS_RD: begin
        if (lo < hi) begin
          state_next = ST_BS_CMP;
        end else if (is_seek) begin
          state_next = ST_IDLE;
          gen_done   = 1'b1;
        end else begin
          state_next = ST_DEACT;
        end
      end
      ST_BS_CMP: begin
        state_next = ST_BS_RD;
      end
      ST_DEACT: begin
        if (deact_cur < bound) begin
          ev_valid = 1'b1;
          ev_kind  = nit_pkg::EV_DEACTIVATE;
          ev_index = deact_cur;
        end else begin
          state_next = ST_IDLE;
          gen_done   = 1'b1;
        end
      end
      ST_SEEK_RST: begin
        ev_valid   = 1'b1;
        state_next = ST_SEEK_RD;
      end
      ST_SEEK_RD: begin
        state_next = (scan < note_count) ? ST_SEEK_CMP : ST_BS_RD;
      end
      ST_SEEK_CMP: begin
        state_next = ST_SEEK_RD;
        if (run_time >= rd_start && run_time <= rd_end) begin
          ev_valid = 1'b1;
          ev_kind  = nit_pkg::EV_ACTIVATE;
          ev_index = scan;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      note_count <= '0;
      act_cur    <= '0;
      deact_cur  <= '0;
      paused     <= 1'b0;
      emitted    <= '0;
      held_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (accept && paused) begin
        // Resume a long run: the word fields carry no meaning here
        paused  <= 1'b0;
        emitted <= '0;
      end else if (!paused) begin
        state <= state_next;

        // Cursor and search bookkeeping
        unique case (state)
          ST_IDLE: begin
            if (accept) begin
              emitted  <= '0;
              run_time <= cmd.time_ms;
              is_seek  <= (cmd.operation == nit_pkg::OP_SEEK);
              if (cmd.operation == nit_pkg::OP_CLEAR) begin
                note_count <= '0;
                act_cur    <= '0;
                deact_cur  <= '0;
              end
              if (load_we) begin
                note_count <= note_count + 1'b1;
                max_last   <= load_max;
              end
            end
          end
          ST_ACT_RD: begin
            if (!(act_cur < note_count)) begin
              lo <= '0;
              hi <= note_count;
            end
          end
          ST_ACT_CMP: begin
            if (run_time < rd_start) begin
              lo <= '0;
              hi <= note_count;
            end else begin
              act_cur <= act_cur + 1'b1;
            end
          end
          ST_BS_RD: begin
            if (!(lo < hi)) begin
              if (is_seek) begin
                deact_cur <= lo;
              end else begin
                bound <= lo;
              end
            end
          end
          ST_BS_CMP: begin
            if (rmax_rd < run_time) begin
              lo <= mid + 1'b1;
            end else begin
              hi <= mid;
            end
          end
          ST_DEACT: begin
            if (deact_cur < bound) begin
              deact_cur <= deact_cur + 1'b1;
            end else begin
              deact_cur <= bound;
            end
          end
          ST_SEEK_RST: begin
            scan  <= '0;
            found <= 1'b0;
          end
          ST_SEEK_RD: begin
            if (!(scan < note_count)) begin
              if (!found) begin
                act_cur <= note_count;
              end
              lo <= '0;
              hi <= note_count;
            end
          end
          ST_SEEK_CMP: begin
            if (!found && rd_start > run_time) begin
              act_cur <= scan;
              found   <= 1'b1;
            end
            scan <= scan + 1'b1;
          end
          default: begin
          end
        endcase

        // Hold one event back so the final word of a run can carry last
        if (ev_valid) begin
          held_valid <= 1'b1;
          held_kind  <= ev_kind;
          held_index <= ev_index;
          if (held_valid) begin
            strobe            <= 1'b1;
            result.event_kind <= held_kind;
            result.note_index <= 12'(held_index);
            result.last       <= 1'b0;
            emitted           <= emitted + 1'b1;
            if (emitted == 7'(nit_pkg::RUN_WORDS - 1)) begin
              paused <= 1'b1;
            end
          end
        end else if (gen_done && held_valid) begin
          held_valid        <= 1'b0;
          strobe            <= 1'b1;
          result.event_kind <= held_kind;
          result.note_index <= 12'(held_index);
          result.last       <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire
